// File: hdl/ss_pkg.sv
// Package: shared types and constants for the substring search block.
package ss_pkg;

    localparam int PATTERN_MAX_DEF = 64;

    typedef enum logic [1:0] {
        OP_PATTERN = 2'd0,
        OP_TEXT    = 2'd1,
        OP_END     = 2'd2
    } t_op;

    typedef struct packed {
        t_op        operation;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic found;
        logic pattern_overflow;
    } t_out_item;

    typedef struct packed {
        logic       active;
        logic       match;
        logic [7:0] pat;
    } t_cell_state;

    typedef struct packed {
        logic       shift;
        logic       text;
        logic       clear;
        logic [7:0] data_byte;
    } t_cell_ctrl;

endpackage

// File: hdl/substring_search_top.sv
// Top level: streaming substring search over a chain of pattern cells.
// One item can be accepted per cycle unless an end result is pending and not yet taken.
// Result of an end transfer is registered and valid the cycle after acceptance.
// Pattern bytes enter at the chain's last cell and shift towards cell 0.
// Synchronous active-low reset empties the pattern and clears both flags.
module substring_search_top
    import ss_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    t_cell_state cell_state [PATTERN_MAX];
    logic        cell_carry [PATTERN_MAX];
    t_cell_ctrl  ctrl;
    t_cell_state tail;

    logic      r_found;
    logic      r_overflow;
    logic      r_out_valid;
    t_out_item r_out_data;
    logic      n_found;
    logic      n_overflow;
    logic      n_out_valid;
    t_out_item n_out_data;

    logic accept;
    logic full;
    logic top_hit;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = cell_state[0].active;
    assign top_hit    = cell_state[PATTERN_MAX-1].active && cell_state[PATTERN_MAX-1].match;
    assign tail       = '{active: 1'b1, match: 1'b0, pat: i_in_data.data_byte};

    always_comb begin
        ctrl = '{shift: 1'b0, text: 1'b0, clear: 1'b0, data_byte: i_in_data.data_byte};
        if (accept) begin
            unique case (i_in_data.operation)
                OP_PATTERN: ctrl.shift = !full;
                OP_TEXT:    ctrl.text  = 1'b1;
                OP_END:     ctrl.clear = 1'b1;
                default:    ctrl.clear = 1'b0;
            endcase
        end
    end

    for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
        ss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (ctrl),
            .i_prev_carry ((k == 0) ? 1'b1 : cell_carry[(k == 0) ? 0 : k-1]),
            .i_next       ((k == PATTERN_MAX-1) ? tail : cell_state[(k == PATTERN_MAX-1) ? k : k+1]),
            .o_state      (cell_state[k]),
            .o_carry      (cell_carry[k])
        );
    end

    always_comb begin
        n_found     = r_found || top_hit;
        n_overflow  = r_overflow;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        if (accept && i_in_data.operation == OP_PATTERN && full) begin
            n_overflow = 1'b1;
        end
        if (ctrl.clear) begin
            n_out_valid = 1'b1;
            n_out_data  = '{found: n_found || !cell_state[PATTERN_MAX-1].active,
                            pattern_overflow: r_overflow};
            n_found     = 1'b0;
            n_overflow  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found     <= 1'b0;
            r_overflow  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_found     <= n_found;
            r_overflow  <= n_overflow;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: hdl/ss_cell.sv
// One cell of the match chain: a pattern byte, its occupancy and its partial-match bit.
module ss_cell
    import ss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cell_ctrl  i_ctrl,
    input  logic        i_prev_carry,
    input  t_cell_state i_next,
    output t_cell_state o_state,
    output logic        o_carry
);

    logic       r_active;
    logic       r_match;
    logic [7:0] r_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_active <= 1'b0;
            r_match  <= 1'b0;
        end else if (i_ctrl.shift) begin
            r_active <= i_next.active;
            r_match  <= i_next.match;
        end else if (i_ctrl.text && r_active) begin
            r_match <= i_prev_carry && (r_pat == i_ctrl.data_byte);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_pat <= i_next.pat;
        end
    end

    // empty cells pass a match through so the first pattern byte sees a start
    assign o_carry = !r_active || r_match;
    assign o_state = '{active: r_active, match: r_match, pat: r_pat};

endmodule

// File: hdl/ss_checker.sv
// Checker: port-level assertions for the substring search top level, with bind.
module ss_checker
    import ss_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    logic in_xfer;
    logic end_xfer;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign end_xfer = in_xfer && i_in_data.operation == OP_END;

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed before transfer");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        end_xfer |=> o_out_valid)
        else $error("end transfer gave no result");

    a_result_only_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid ##1 o_out_valid |-> $past(end_xfer))
        else $error("result without end transfer");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with no result pending");

endmodule

bind substring_search_top ss_checker u_ss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
